/* hw/rtl/lpbe_pkg.sv */
// Shared constants, codes and types for the pixel low-bit embedder.
`default_nettype none

package lpbe_pkg;

    localparam int BUFFER_BITS = 64;
    localparam int HDR_BITS    = 31;
    localparam int CNT_W       = $clog2(BUFFER_BITS + 1);
    localparam int AVL_W       = $clog2(HDR_BITS + BUFFER_BITS + 1);
    localparam int STREAM_W    = 32;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 31;

    localparam logic [1:0] REQ_PUSH  = 2'd0;
    localparam logic [1:0] REQ_END   = 2'd1;
    localparam logic [1:0] REQ_PIXEL = 2'd2;

    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_END   = 2'd1;
    localparam logic [1:0] OP_PIXEL = 2'd2;

    localparam logic [1:0] FMT_5551   = 2'd0;
    localparam logic [1:0] FMT_RGB24  = 2'd1;
    localparam logic [1:0] FMT_RGBA32 = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SECRET_SIZE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LSB_RED      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LSB_GREEN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LSB_BLUE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LSB_ALPHA    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_FORMAT = 3'd5;

    typedef struct packed {
        logic [30:0] secret_size;
        logic [3:0]  lsb_red;
        logic [3:0]  lsb_green;
        logic [3:0]  lsb_blue;
        logic [3:0]  lsb_alpha;
        logic [1:0]  pixel_format;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] data;
    } t_op;

    typedef struct packed {
        logic [31:0] pixel_out;
        logic [5:0]  bits_taken;
        logic        underrun;
        logic        overflow;
    } t_res;

endpackage

`default_nettype wire

/* hw/rtl/lsb_pixel_bit_embedder.sv */
// Top level of the pixel low-bit embedder: config registers, front end, queue, engine.
`default_nettype none

// Channel   Handshake             Payload
// input     push / full           i_req_type, i_secret_byte, i_pixel_in
// result    empty / pop           o_pixel_out, o_bits_taken, o_underrun, o_overflow
// config    i_cfg_we              i_cfg_index, i_cfg_data
//
// One transaction per cycle on each side, unless full or empty stalls that side.
// A pixel result reaches the result ports through its queue entry and then the result register.
// Synchronous active-low reset; no clearing pass is needed.
// full rises when the two-entry queue is full; pixels stall in the queue while the
// result register holds an unpopped result, and push and end transactions queued
// behind such a pixel wait with it.

module lsb_pixel_bit_embedder (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                push,
    output logic                                     full,
    input  wire logic [1:0]                          i_req_type,
    input  wire logic [7:0]                          i_secret_byte,
    input  wire logic [31:0]                         i_pixel_in,
    output logic                                     empty,
    input  wire logic                                pop,
    output logic [31:0]                              o_pixel_out,
    output logic [5:0]                               o_bits_taken,
    output logic                                     o_underrun,
    output logic                                     o_overflow,
    input  wire logic                                i_cfg_we,
    input  wire logic [lpbe_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [lpbe_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    lpbe_pkg::t_cfg r_cfg;
    lpbe_pkg::t_op  q_wr_op;
    lpbe_pkg::t_op  q_rd_op;
    lpbe_pkg::t_res res;
    logic           q_wr;
    logic           q_full;
    logic           q_empty;
    logic           q_rd;
    logic           res_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.secret_size  <= '0;
            r_cfg.lsb_red      <= 4'd1;
            r_cfg.lsb_green    <= 4'd1;
            r_cfg.lsb_blue     <= 4'd1;
            r_cfg.lsb_alpha    <= 4'd0;
            r_cfg.pixel_format <= lpbe_pkg::FMT_RGB24;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                lpbe_pkg::CFG_SECRET_SIZE:  r_cfg.secret_size  <= i_cfg_data;
                lpbe_pkg::CFG_LSB_RED:      r_cfg.lsb_red      <= i_cfg_data[3:0];
                lpbe_pkg::CFG_LSB_GREEN:    r_cfg.lsb_green    <= i_cfg_data[3:0];
                lpbe_pkg::CFG_LSB_BLUE:     r_cfg.lsb_blue     <= i_cfg_data[3:0];
                lpbe_pkg::CFG_LSB_ALPHA:    r_cfg.lsb_alpha    <= i_cfg_data[3:0];
                lpbe_pkg::CFG_PIXEL_FORMAT: r_cfg.pixel_format <= i_cfg_data[1:0];
                default: r_cfg <= r_cfg;
            endcase
        end
    end

    lpbe_front u_front (
        .push          (push),
        .full          (full),
        .i_req_type    (i_req_type),
        .i_secret_byte (i_secret_byte),
        .i_pixel_in    (i_pixel_in),
        .i_q_full      (q_full),
        .o_q_wr        (q_wr),
        .o_q_op        (q_wr_op)
    );

    lpbe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_wr_op (q_wr_op),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_rd_op (q_rd_op),
        .o_empty (q_empty)
    );

    lpbe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_op_valid  (!q_empty),
        .i_op        (q_rd_op),
        .o_op_pop    (q_rd),
        .i_res_pop   (pop),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    assign empty        = !res_valid;
    assign o_pixel_out  = res.pixel_out;
    assign o_bits_taken = res.bits_taken;
    assign o_underrun   = res.underrun;
    assign o_overflow   = res.overflow;

endmodule

`default_nettype wire

/* hw/rtl/lpbe_front.sv */
// Front end: accepts input transactions and classifies them into queue operations.
`default_nettype none

module lpbe_front (
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [7:0]  i_secret_byte,
    input  wire logic [31:0] i_pixel_in,
    input  wire logic        i_q_full,
    output logic             o_q_wr,
    output lpbe_pkg::t_op    o_q_op
);

    logic accept;

    assign full   = i_q_full;
    assign accept = push && !i_q_full;

    always_comb begin
        o_q_wr      = 1'b0;
        o_q_op.kind = lpbe_pkg::OP_PIXEL;
        o_q_op.data = i_pixel_in;
        case (i_req_type)
            lpbe_pkg::REQ_PUSH: begin
                o_q_wr      = accept;
                o_q_op.kind = lpbe_pkg::OP_PUSH;
                o_q_op.data = {24'd0, i_secret_byte};
            end
            lpbe_pkg::REQ_END: begin
                o_q_wr      = accept;
                o_q_op.kind = lpbe_pkg::OP_END;
                o_q_op.data = 32'd0;
            end
            lpbe_pkg::REQ_PIXEL: begin
                o_q_wr      = accept;
                o_q_op.kind = lpbe_pkg::OP_PIXEL;
                o_q_op.data = i_pixel_in;
            end
            default: begin
                o_q_wr = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hw/rtl/lpbe_queue.sv */
// Short operation queue between the front end and the embedding engine.
`default_nettype none

module lpbe_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_wr,
    input  wire lpbe_pkg::t_op i_wr_op,
    output logic               o_full,
    input  wire logic          i_rd,
    output lpbe_pkg::t_op      o_rd_op,
    output logic               o_empty
);

    lpbe_pkg::t_op                    r_mem [lpbe_pkg::QUEUE_DEPTH];
    logic [lpbe_pkg::QPTR_W-1:0]      r_wptr;
    logic [lpbe_pkg::QPTR_W-1:0]      r_rptr;
    logic [lpbe_pkg::QCNT_W-1:0]      r_cnt;
    logic                             do_wr;
    logic                             do_rd;

    assign o_full  = (r_cnt == lpbe_pkg::QCNT_W'(lpbe_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rd_op = r_mem[r_rptr];
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;

    function automatic logic [lpbe_pkg::QPTR_W-1:0] ptr_inc(
        input logic [lpbe_pkg::QPTR_W-1:0] p
    );
        if (p == lpbe_pkg::QPTR_W'(lpbe_pkg::QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wptr] <= i_wr_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_wr) begin
                r_wptr <= ptr_inc(r_wptr);
            end
            if (do_rd) begin
                r_rptr <= ptr_inc(r_rptr);
            end
            if (do_wr && !do_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/lpbe_back.sv */
// Embedding engine: bit FIFO, header counter and per-pixel bit placement.
`default_nettype none

module lpbe_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire lpbe_pkg::t_cfg i_cfg,
    input  wire logic          i_op_valid,
    input  wire lpbe_pkg::t_op i_op,
    output logic               o_op_pop,
    input  wire logic          i_res_pop,
    output logic               o_res_valid,
    output lpbe_pkg::t_res     o_res
);

    logic [4:0]                         r_hdr_left;
    logic [lpbe_pkg::BUFFER_BITS-1:0]   r_fifo;
    logic [lpbe_pkg::CNT_W-1:0]         r_count;
    logic                               r_ended;
    logic                               r_ovf;
    logic                               r_res_valid;
    lpbe_pkg::t_res                     r_res;

    logic [4:0]                         n_hdr_left;
    logic [lpbe_pkg::BUFFER_BITS-1:0]   n_fifo;
    logic [lpbe_pkg::CNT_W-1:0]         n_count;
    logic                               n_ended;
    logic                               n_ovf;
    lpbe_pkg::t_res                     n_res;

    logic                               res_free;
    logic                               op_go;
    logic                               is_pixel;
    logic [3:0]                         cw;
    logic [3:0]                         ca, cr, cg, cb;
    logic [5:0]                         need;
    logic [5:0]                         off_r, off_g, off_b;
    logic [lpbe_pkg::AVL_W-1:0]         avail;
    logic [30:0]                        hdr_rem;
    logic [lpbe_pkg::STREAM_W-1:0]      stream;
    logic [7:0]                         pa, pr, pg, pb;
    logic [7:0]                         va, vr, vg, vb;
    logic [31:0]                        pix_out;
    logic [5:0]                         taken;
    logic [4:0]                         hdr_used;
    logic [5:0]                         fifo_used;
    logic                               under;

    function automatic logic [3:0] clip(input logic [3:0] v, input logic [3:0] lim);
        return (v < lim) ? v : lim;
    endfunction

    function automatic logic [7:0] embed(
        input logic [7:0]                    val,
        input logic [3:0]                    cnt,
        input logic [5:0]                    off,
        input logic [lpbe_pkg::STREAM_W-1:0] s,
        input logic [lpbe_pkg::AVL_W-1:0]    avl
    );
        logic [7:0]                 v;
        logic [lpbe_pkg::AVL_W-1:0] idx;
        v = val;
        for (int p = 0; p < 8; p++) begin
            idx = lpbe_pkg::AVL_W'(off) + lpbe_pkg::AVL_W'(p);
            if ((4'(p) < cnt) && (idx < avl)) begin
                v[p] = s[idx[4:0]];
            end
        end
        return v;
    endfunction

    assign is_pixel    = (i_op.kind == lpbe_pkg::OP_PIXEL);
    assign res_free    = !r_res_valid || i_res_pop;
    assign op_go       = i_op_valid && (!is_pixel || res_free);
    assign o_op_pop    = op_go;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    // channel layout
    always_comb begin
        case (i_cfg.pixel_format)
            lpbe_pkg::FMT_5551: begin
                cw = 4'd5;
                pr = {3'd0, i_op.data[14:10]};
                pg = {3'd0, i_op.data[9:5]};
                pb = {3'd0, i_op.data[4:0]};
            end
            lpbe_pkg::FMT_RGB24: begin
                cw = 4'd8;
                pr = i_op.data[23:16];
                pg = i_op.data[15:8];
                pb = i_op.data[7:0];
            end
            default: begin
                cw = 4'd8;
                pr = i_op.data[31:24];
                pg = i_op.data[23:16];
                pb = i_op.data[15:8];
            end
        endcase
    end

    assign pa    = i_op.data[7:0];
    assign ca    = clip(i_cfg.lsb_alpha, 4'd8);
    assign cr    = clip(i_cfg.lsb_red, cw);
    assign cg    = clip(i_cfg.lsb_green, cw);
    assign cb    = clip(i_cfg.lsb_blue, cw);
    assign off_r = 6'(ca);
    assign off_g = off_r + 6'(cr);
    assign off_b = off_g + 6'(cg);
    assign need  = off_b + 6'(cb);

    // header bits first, then FIFO bits
    assign avail   = lpbe_pkg::AVL_W'(r_hdr_left) + lpbe_pkg::AVL_W'(r_count);
    assign hdr_rem = i_cfg.secret_size >> (5'd31 - r_hdr_left);
    assign stream  = {1'b0, hdr_rem} | (r_fifo[lpbe_pkg::STREAM_W-1:0] << r_hdr_left);

    assign va = embed(pa, ca, 6'd0, stream, avail);
    assign vr = embed(pr, cr, off_r, stream, avail);
    assign vg = embed(pg, cg, off_g, stream, avail);
    assign vb = embed(pb, cb, off_b, stream, avail);

    always_comb begin
        case (i_cfg.pixel_format)
            lpbe_pkg::FMT_5551:  pix_out = {17'd0, vr[4:0], vg[4:0], vb[4:0]};
            lpbe_pkg::FMT_RGB24: pix_out = {8'd0, vr, vg, vb};
            default:             pix_out = {vr, vg, vb, va};
        endcase
    end

    assign taken     = (lpbe_pkg::AVL_W'(need) < avail) ? need : avail[5:0];
    assign under     = (lpbe_pkg::AVL_W'(need) > avail) && !r_ended;
    assign hdr_used  = (taken < 6'(r_hdr_left)) ? taken[4:0] : r_hdr_left;
    assign fifo_used = taken - 6'(hdr_used);

    always_comb begin
        n_hdr_left = r_hdr_left;
        n_fifo     = r_fifo;
        n_count    = r_count;
        n_ended    = r_ended;
        n_ovf      = r_ovf;
        n_res.pixel_out  = pix_out;
        n_res.bits_taken = taken;
        n_res.underrun   = under;
        n_res.overflow   = r_ovf;
        case (i_op.kind)
            lpbe_pkg::OP_PUSH: begin
                if (!r_ended) begin
                    if (r_count > lpbe_pkg::CNT_W'(lpbe_pkg::BUFFER_BITS - 8)) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_fifo  = r_fifo |
                                  (lpbe_pkg::BUFFER_BITS'(i_op.data[7:0]) << r_count);
                        n_count = r_count + lpbe_pkg::CNT_W'(8);
                    end
                end
            end
            lpbe_pkg::OP_END: begin
                n_ended = 1'b1;
            end
            lpbe_pkg::OP_PIXEL: begin
                n_hdr_left = r_hdr_left - hdr_used;
                n_fifo     = r_fifo >> fifo_used;
                n_count    = r_count - lpbe_pkg::CNT_W'(fifo_used);
            end
            default: begin
                n_ended = r_ended;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_left  <= 5'd31;
            r_fifo      <= '0;
            r_count     <= '0;
            r_ended     <= 1'b0;
            r_ovf       <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            if (op_go) begin
                r_hdr_left <= n_hdr_left;
                r_fifo     <= n_fifo;
                r_count    <= n_count;
                r_ended    <= n_ended;
                r_ovf      <= n_ovf;
            end
            if (op_go && is_pixel) begin
                r_res_valid <= 1'b1;
            end else if (i_res_pop) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (op_go && is_pixel) begin
            r_res <= n_res;
        end
    end

endmodule

`default_nettype wire

/* tb/tb_lsb_pixel_bit_embedder.sv */
// Self-checking testbench for lsb_pixel_bit_embedder: directed and random traffic, predicted results.
`timescale 1ns / 100ps

module tb_lsb_pixel_bit_embedder;

    localparam logic [1:0] REQ_NONE  = 2'd3;
    localparam logic [1:0] FMT_SPARE = 2'd3;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_AT        = 60;
    localparam int HOLD_LEN       = 64;

    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  sbyte;
        logic [31:0] pix;
    } t_pix_req;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            push = 1'b0;
    logic                            full;
    logic [1:0]                      i_req_type = '0;
    logic [7:0]                      i_secret_byte = '0;
    logic [31:0]                     i_pixel_in = '0;
    logic                            empty;
    logic                            pop = 1'b0;
    logic [31:0]                     o_pixel_out;
    logic [5:0]                      o_bits_taken;
    logic                            o_underrun;
    logic                            o_overflow;
    logic                            i_cfg_we = 1'b0;
    logic [lpbe_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [lpbe_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    t_pix_req       req_q[$];
    lpbe_pkg::t_res pixel_q[$];
    t_pix_req       drv_req;
    int unsigned    send_gap_pct = 0;
    int unsigned    recv_gap_pct = 0;
    int unsigned    n_err = 0;
    int unsigned    px_seen = 0;
    int unsigned    hold_left = 0;
    bit             hold_done = 1'b0;
    int unsigned    idle_cycles = 0;

    // predictor state
    lpbe_pkg::t_cfg cfg_m = '{secret_size: '0, lsb_red: 4'd1, lsb_green: 4'd1,
                              lsb_blue: 4'd1, lsb_alpha: 4'd0,
                              pixel_format: lpbe_pkg::FMT_RGB24};
    int unsigned    hdr_left = lpbe_pkg::HDR_BITS;
    bit             secret_bits[$];
    bit             ended_m = 1'b0;
    bit             ovf_m = 1'b0;

    wire in_fire  = push && !full;
    wire out_fire = pop && !empty;

    lsb_pixel_bit_embedder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_req_type    (i_req_type),
        .i_secret_byte (i_secret_byte),
        .i_pixel_in    (i_pixel_in),
        .empty         (empty),
        .pop           (pop),
        .o_pixel_out   (o_pixel_out),
        .o_bits_taken  (o_bits_taken),
        .o_underrun    (o_underrun),
        .o_overflow    (o_overflow),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // 1: bit delivered, 0: stream done, -1: bit missing
    function automatic int take_bit(output bit b);
        b = 1'b0;
        if (hdr_left > 0) begin
            b = cfg_m.secret_size[lpbe_pkg::HDR_BITS - hdr_left];
            hdr_left--;
            return 1;
        end
        if (secret_bits.size() != 0) begin
            b = secret_bits.pop_front();
            return 1;
        end
        return ended_m ? 0 : -1;
    endfunction

    function automatic logic [7:0] embed_chan(input logic [7:0] val, input int unsigned cnt,
                                              inout int unsigned taken, inout bit under);
        bit b;
        int r;
        for (int pos = 0; pos < cnt; pos++) begin
            r = take_bit(b);
            if (r == 1) begin
                val[pos] = b;
                taken++;
            end else if (r < 0) begin
                under = 1'b1;
            end
        end
        return val;
    endfunction

    function automatic int unsigned clip_cnt(input logic [3:0] c, input int unsigned lim);
        return (c < lim) ? c : lim;
    endfunction

    function automatic void embed_req(input t_pix_req rq);
        lpbe_pkg::t_res res;
        logic [7:0]     v;
        logic [7:0]     cmask;
        int unsigned    cw, sr, sg, sb, taken;
        bit             under;
        case (rq.kind)
            lpbe_pkg::REQ_PUSH: begin
                if (!ended_m) begin
                    if (secret_bits.size() + 8 > lpbe_pkg::BUFFER_BITS) begin
                        ovf_m = 1'b1;
                    end else begin
                        for (int k = 0; k < 8; k++) secret_bits.push_back(rq.sbyte[k]);
                    end
                end
            end
            lpbe_pkg::REQ_END: begin
                ended_m = 1'b1;
            end
            lpbe_pkg::REQ_PIXEL: begin
                res = '0;
                taken = 0;
                under = 1'b0;
                case (cfg_m.pixel_format)
                    lpbe_pkg::FMT_5551: begin
                        cw = 5; sr = 10; sg = 5; sb = 0;
                    end
                    lpbe_pkg::FMT_RGB24: begin
                        cw = 8; sr = 16; sg = 8; sb = 0;
                    end
                    default: begin
                        cw = 8; sr = 24; sg = 16; sb = 8;
                    end
                endcase
                cmask = 8'((1 << cw) - 1);
                v = embed_chan(rq.pix[7:0], clip_cnt(cfg_m.lsb_alpha, 8), taken, under);
                if (cfg_m.pixel_format >= lpbe_pkg::FMT_RGBA32) res.pixel_out[7:0] = v;
                v = embed_chan(8'(rq.pix >> sr) & cmask, clip_cnt(cfg_m.lsb_red, cw), taken,
                               under);
                res.pixel_out |= 32'(v & cmask) << sr;
                v = embed_chan(8'(rq.pix >> sg) & cmask, clip_cnt(cfg_m.lsb_green, cw), taken,
                               under);
                res.pixel_out |= 32'(v & cmask) << sg;
                v = embed_chan(8'(rq.pix >> sb) & cmask, clip_cnt(cfg_m.lsb_blue, cw), taken,
                               under);
                res.pixel_out |= 32'(v & cmask) << sb;
                res.bits_taken = 6'(taken);
                res.underrun = under;
                res.overflow = ovf_m;
                pixel_q.push_back(res);
            end
            default: ;
        endcase
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_fire) embed_req(drv_req);
            if (!push || !full) begin
                if (req_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    drv_req = req_q.pop_front();
                    push          <= 1'b1;
                    i_req_type    <= drv_req.kind;
                    i_secret_byte <= drv_req.sbyte;
                    i_pixel_in    <= drv_req.pix;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        lpbe_pkg::t_res exp_res;
        if (i_rst_n) begin
            if (out_fire) begin
                if (pixel_q.size() == 0) begin
                    $error("unexpected pixel transaction: pixel_out %h", o_pixel_out);
                    n_err++;
                end else begin
                    exp_res = pixel_q.pop_front();
                    if (o_pixel_out !== exp_res.pixel_out) begin
                        $error("pixel_out expected %h got %h", exp_res.pixel_out, o_pixel_out);
                        n_err++;
                    end
                    if (o_bits_taken !== exp_res.bits_taken) begin
                        $error("bits_taken expected %0d got %0d", exp_res.bits_taken,
                               o_bits_taken);
                        n_err++;
                    end
                    if (o_underrun !== exp_res.underrun) begin
                        $error("underrun expected %b got %b", exp_res.underrun, o_underrun);
                        n_err++;
                    end
                    if (o_overflow !== exp_res.overflow) begin
                        $error("overflow expected %b got %b", exp_res.overflow, o_overflow);
                        n_err++;
                    end
                end
                px_seen++;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (!hold_done && px_seen == HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= recv_gap_pct);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (in_fire || out_fire) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("lsb_pixel_bit_embedder: mismatch");
            $finish;
        end
    end

    task automatic wait_idle();
        do @(negedge i_clk); while (req_q.size() != 0 || push || pixel_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [lpbe_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lpbe_pkg::CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            lpbe_pkg::CFG_SECRET_SIZE:  cfg_m.secret_size  = val;
            lpbe_pkg::CFG_LSB_RED:      cfg_m.lsb_red      = val[3:0];
            lpbe_pkg::CFG_LSB_GREEN:    cfg_m.lsb_green    = val[3:0];
            lpbe_pkg::CFG_LSB_BLUE:     cfg_m.lsb_blue     = val[3:0];
            lpbe_pkg::CFG_LSB_ALPHA:    cfg_m.lsb_alpha    = val[3:0];
            lpbe_pkg::CFG_PIXEL_FORMAT: cfg_m.pixel_format = val[1:0];
            default: ;
        endcase
    endtask

    task automatic set_mode(input logic [30:0] ss, input logic [3:0] r, input logic [3:0] g,
                            input logic [3:0] b, input logic [3:0] a, input logic [1:0] fmt);
        wait_idle();
        cfg_write(lpbe_pkg::CFG_SECRET_SIZE, ss);
        cfg_write(lpbe_pkg::CFG_LSB_RED, 31'(r));
        cfg_write(lpbe_pkg::CFG_LSB_GREEN, 31'(g));
        cfg_write(lpbe_pkg::CFG_LSB_BLUE, 31'(b));
        cfg_write(lpbe_pkg::CFG_LSB_ALPHA, 31'(a));
        cfg_write(lpbe_pkg::CFG_PIXEL_FORMAT, 31'(fmt));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic [3:0] pick_cnt();
        return ($urandom_range(7) == 0) ? 4'($urandom_range(15, 9)) : 4'($urandom_range(8));
    endfunction

    task automatic add_req(input logic [1:0] kind, input logic [7:0] sbyte,
                           input logic [31:0] pix);
        t_pix_req rq;
        rq.kind  = kind;
        rq.sbyte = sbyte;
        rq.pix   = pix;
        req_q.push_back(rq);
    endtask

    task automatic queue_random(input int n, input int unsigned push_pct);
        t_pix_req    rq;
        int unsigned roll;
        repeat (n) begin
            roll = $urandom_range(99);
            rq.sbyte = 8'($urandom);
            rq.pix   = $urandom;
            if (roll < push_pct) rq.kind = lpbe_pkg::REQ_PUSH;
            else if (roll < 95) rq.kind = lpbe_pkg::REQ_PIXEL;
            else rq.kind = REQ_NONE;
            case ($urandom_range(15))
                0: rq.pix = '0;
                1: rq.pix = '1;
                default: ;
            endcase
            req_q.push_back(rq);
        end
    endtask

    initial begin
        int unsigned send_pct[3];
        int unsigned recv_pct[3];
        send_pct = '{17, 50, 0};
        recv_pct = '{50, 17, 0};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // header in one pixel, then a missing bit
        set_mode(31'h5A3C96E1, 4'd8, 4'd8, 4'd8, 4'd8, lpbe_pkg::FMT_RGBA32);
        add_req(lpbe_pkg::REQ_PIXEL, 8'h00, 32'h0000_0000);
        add_req(lpbe_pkg::REQ_PUSH, 8'hA5, 32'h0);
        add_req(lpbe_pkg::REQ_PUSH, 8'h3C, 32'h0);
        add_req(lpbe_pkg::REQ_PUSH, 8'hFF, 32'h0);
        add_req(lpbe_pkg::REQ_PUSH, 8'h00, 32'h0);
        add_req(lpbe_pkg::REQ_PIXEL, 8'h00, 32'hFFFF_FFFF);
        add_req(lpbe_pkg::REQ_PIXEL, 8'hFF, 32'h1234_5678);
        add_req(REQ_NONE, 8'hFF, 32'hFFFF_FFFF);

        // counts above channel width, 5551 alpha dropped
        set_mode(31'h0, 4'd15, 4'd15, 4'd15, 4'd15, lpbe_pkg::FMT_5551);
        add_req(lpbe_pkg::REQ_PUSH, 8'h81, 32'h0);
        add_req(lpbe_pkg::REQ_PUSH, 8'h7E, 32'h0);
        add_req(lpbe_pkg::REQ_PUSH, 8'h55, 32'h0);
        add_req(lpbe_pkg::REQ_PUSH, 8'hAA, 32'h0);
        add_req(lpbe_pkg::REQ_PUSH, 8'h0F, 32'h0);
        add_req(lpbe_pkg::REQ_PUSH, 8'hF0, 32'h0);
        add_req(lpbe_pkg::REQ_PIXEL, 8'h00, 32'hFFFF_FFFF);
        add_req(lpbe_pkg::REQ_PIXEL, 8'h00, 32'h0000_8000);
        add_req(lpbe_pkg::REQ_PIXEL, 8'h00, 32'hDEAD_BEEF);

        set_mode(31'h7FFFFFFF, 4'd0, 4'd0, 4'd0, 4'd0, FMT_SPARE);
        add_req(lpbe_pkg::REQ_PIXEL, 8'h00, 32'hA5A5_A5A5);
        add_req(lpbe_pkg::REQ_PUSH, 8'h5A, 32'h0);

        set_mode(31'h7FFFFFFF, 4'd0, 4'd8, 4'd1, 4'd3, lpbe_pkg::FMT_RGB24);
        add_req(lpbe_pkg::REQ_PIXEL, 8'h00, 32'hC3C3_C3C3);

        for (int s = 0; s < 3; s++) begin
            for (int p = 0; p < 3; p++) begin
                set_mode(31'($urandom), pick_cnt(), pick_cnt(), pick_cnt(), pick_cnt(),
                         2'($urandom_range(3)));
                send_gap_pct = send_pct[s];
                recv_gap_pct = recv_pct[s];
                queue_random(85, $urandom_range(70, 20));
            end
        end

        // full buffer, end marker, push after end, drain past the end
        set_mode(31'h7FFFFFFF, 4'd2, 4'd2, 4'd2, 4'd2, lpbe_pkg::FMT_RGBA32);
        repeat (9) add_req(lpbe_pkg::REQ_PUSH, 8'($urandom), 32'h0);
        add_req(lpbe_pkg::REQ_PIXEL, 8'h00, $urandom);
        add_req(lpbe_pkg::REQ_END, 8'h00, 32'h0);
        add_req(lpbe_pkg::REQ_PUSH, 8'hFF, 32'h0);
        repeat (10) add_req(lpbe_pkg::REQ_PIXEL, 8'h00, $urandom);
        send_gap_pct = send_pct[0];
        recv_gap_pct = recv_pct[0];
        queue_random(60, 40);

        wait_idle();
        if (n_err == 0) begin
            $display("lsb_pixel_bit_embedder: match");
        end else begin
            $display("lsb_pixel_bit_embedder: mismatch");
        end
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/lpbe_pkg.sv
hw/rtl/lpbe_front.sv
hw/rtl/lpbe_queue.sv
hw/rtl/lpbe_back.sv
hw/rtl/lsb_pixel_bit_embedder.sv
tb/tb_lsb_pixel_bit_embedder.sv
